/* hdl/ppt_pkg.sv */
// ppt_pkg: shared types, constants and the arctangent table of the planar pose transform
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

	localparam int unsigned COORD_W           = 32;
	localparam int unsigned HEADING_W         = 26;
	localparam int unsigned ANGLE_W           = 27;
	localparam int unsigned CORDIC_W          = 34;
	localparam int unsigned CORDIC_FRAC       = 30;
	localparam int unsigned CORDIC_STAGES_DEF = 18;
	localparam int unsigned FRACTION_BITS_DEF = 16;
	localparam int unsigned PREP_STAGES       = 3;
	localparam int unsigned BACK_STAGES       = 4;

	localparam longint HALF_TURN_DEG = 180;
	localparam longint DEG_SCALE     = 65536;
	localparam longint HALF_TURN     = HALF_TURN_DEG * DEG_SCALE;
	localparam longint QUARTER_TURN  = HALF_TURN / 2;
	localparam longint FULL_TURN     = HALF_TURN * 2;

	localparam logic signed [CORDIC_W-1:0] CORDIC_K = CORDIC_W'(652032874);

	typedef enum logic [1:0] {
		MODE_ROT = 2'd0,
		MODE_ADD = 2'd1,
		MODE_SUB = 2'd2,
		MODE_INV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_POSE_X       = 2'd0,
		CFG_POSE_Y       = 2'd1,
		CFG_POSE_HEADING = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                      flip;
		mode_t                     mode;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] px;
	} item_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest
	function automatic logic signed [ANGLE_W-1:0] atan_deg(input int unsigned idx);
		logic signed [ANGLE_W-1:0] a;
		case (idx)
			0:  a = ANGLE_W'(2949120);
			1:  a = ANGLE_W'(1740967);
			2:  a = ANGLE_W'(919879);
			3:  a = ANGLE_W'(466945);
			4:  a = ANGLE_W'(234379);
			5:  a = ANGLE_W'(117304);
			6:  a = ANGLE_W'(58666);
			7:  a = ANGLE_W'(29335);
			8:  a = ANGLE_W'(14668);
			9:  a = ANGLE_W'(7334);
			10: a = ANGLE_W'(3667);
			11: a = ANGLE_W'(1833);
			12: a = ANGLE_W'(917);
			13: a = ANGLE_W'(458);
			14: a = ANGLE_W'(229);
			15: a = ANGLE_W'(115);
			16: a = ANGLE_W'(57);
			17: a = ANGLE_W'(29);
			18: a = ANGLE_W'(14);
			19: a = ANGLE_W'(7);
			20: a = ANGLE_W'(4);
			21: a = ANGLE_W'(2);
			22: a = ANGLE_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

/* hdl/ppt_angle_prep.sv */
// ppt_angle_prep: three stages that negate (for MODE_INV), wrap and fold the heading into [-90, 90] degrees
// depends on ppt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppt_angle_prep (
	input  logic                                 clk,
	input  logic [ppt_pkg::PREP_STAGES-1:0]      ld,
	input  logic signed [ppt_pkg::HEADING_W-1:0] heading,
	input  ppt_pkg::item_t                       item_in,
	output logic signed [ppt_pkg::ANGLE_W-1:0]   z_out,
	output ppt_pkg::item_t                       item_out
);
	import ppt_pkg::*;

	localparam logic signed [ANGLE_W-1:0] HALF_A    = ANGLE_W'(HALF_TURN);
	localparam logic signed [ANGLE_W-1:0] FULL_A    = ANGLE_W'(FULL_TURN);
	localparam logic signed [ANGLE_W-1:0] QUARTER_A = ANGLE_W'(QUARTER_TURN);

	logic signed [ANGLE_W-1:0] h_ext;
	logic signed [ANGLE_W-1:0] h_s1, m_s2, z_s3;
	logic signed [ANGLE_W-1:0] m_nxt, z_nxt;
	logic                      flip_nxt;
	item_t                     item_s1, item_s2, item_s3;
	item_t                     item_nxt;

	assign h_ext = ANGLE_W'(heading);

	always_comb begin
		if (h_s1 >= HALF_A) begin
			m_nxt = h_s1 - FULL_A;
		end else if (h_s1 < -HALF_A) begin
			m_nxt = h_s1 + FULL_A;
		end else begin
			m_nxt = h_s1;
		end
	end

	always_comb begin
		if (m_s2 > QUARTER_A) begin
			z_nxt    = m_s2 - HALF_A;
			flip_nxt = 1'b1;
		end else if (m_s2 < -QUARTER_A) begin
			z_nxt    = m_s2 + HALF_A;
			flip_nxt = 1'b1;
		end else begin
			z_nxt    = m_s2;
			flip_nxt = 1'b0;
		end
	end

	always_comb begin
		item_nxt      = item_s2;
		item_nxt.flip = flip_nxt;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			h_s1    <= (item_in.mode == MODE_INV) ? -h_ext : h_ext;
			item_s1 <= item_in;
		end
		if (ld[1]) begin
			m_s2    <= m_nxt;
			item_s2 <= item_s1;
		end
		if (ld[2]) begin
			z_s3    <= z_nxt;
			item_s3 <= item_nxt;
		end
	end

	assign z_out    = z_s3;
	assign item_out = item_s3;

endmodule

`default_nettype wire

/* hdl/ppt_cordic_cell.sv */
// ppt_cordic_cell: one rotation step of the degree-based cordic, passes the beat to the next cell
// depends on ppt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppt_cordic_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic                                clk,
	input  logic                                ld,
	input  logic signed [ppt_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [ppt_pkg::CORDIC_W-1:0] y_in,
	input  logic signed [ppt_pkg::ANGLE_W-1:0]  z_in,
	input  ppt_pkg::item_t                      item_in,
	output logic signed [ppt_pkg::CORDIC_W-1:0] x_out,
	output logic signed [ppt_pkg::CORDIC_W-1:0] y_out,
	output logic signed [ppt_pkg::ANGLE_W-1:0]  z_out,
	output ppt_pkg::item_t                      item_out
);
	import ppt_pkg::*;

	localparam logic signed [ANGLE_W-1:0] ATAN = atan_deg(SHIFT);

	logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
	logic signed [ANGLE_W-1:0]  z_q;
	item_t                      item_q;

	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (ld) begin
			item_q <= item_in;
			if (!z_in[ANGLE_W-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end
		end
	end

	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;
	assign item_out = item_q;

endmodule

`default_nettype wire

/* hdl/ppt_rotate_out.sv */
// ppt_rotate_out: rounds sine and cosine, multiplies, sums, applies offsets and saturates
// four stages, the last one is the output register; depends on ppt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppt_rotate_out #(
	parameter int unsigned FRACTION_BITS = ppt_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic [ppt_pkg::BACK_STAGES-1:0]     ld,
	input  logic signed [ppt_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [ppt_pkg::CORDIC_W-1:0] y_in,
	input  ppt_pkg::item_t                      item_in,
	input  logic signed [ppt_pkg::COORD_W-1:0]  pose_x,
	input  logic signed [ppt_pkg::COORD_W-1:0]  pose_y,
	output logic signed [ppt_pkg::COORD_W-1:0]  result_x,
	output logic signed [ppt_pkg::COORD_W-1:0]  result_y,
	output logic                                saturated
);
	import ppt_pkg::*;

	localparam int unsigned TRIG_SH = CORDIC_FRAC - FRACTION_BITS;
	localparam int unsigned CW      = FRACTION_BITS + 3;
	localparam int unsigned PW      = COORD_W + CW;
	localparam int unsigned SW      = PW + 1;
	localparam int unsigned RW      = SW - FRACTION_BITS;

	localparam logic signed [CORDIC_W-1:0] TRIG_HALF = CORDIC_W'(1) << (TRIG_SH - 1);
	localparam logic signed [SW-1:0]       RND       = SW'(1) << (FRACTION_BITS - 1);

	logic signed [CORDIC_W-1:0] tx, ty;
	logic signed [CW-1:0]       c_rnd, s_rnd;
	logic signed [CW-1:0]       cos_s1, sin_s1;
	item_t                      item_s1;
	logic signed [PW-1:0]       pxc_s2, pys_s2, pxs_s2, pyc_s2;
	item_t                      item_s2;
	logic signed [SW-1:0]       sum_x, sum_y;
	logic signed [RW-1:0]       rx_nxt, ry_nxt;
	logic signed [RW-1:0]       rx_s3, ry_s3;
	logic signed [COORD_W-1:0]  cx_nxt, cy_nxt;
	logic                       ovx, ovy;
	logic signed [COORD_W-1:0]  rx_s4, ry_s4;
	logic                       sat_s4;

	// round the q4.30 cordic outputs to the output fraction
	assign tx    = (x_in + TRIG_HALF) >>> TRIG_SH;
	assign ty    = (y_in + TRIG_HALF) >>> TRIG_SH;
	assign c_rnd = tx[CW-1:0];
	assign s_rnd = ty[CW-1:0];

	always_comb begin
		sum_x = (SW'(pxc_s2) - SW'(pys_s2) + RND) >>> FRACTION_BITS;
		sum_y = (SW'(pxs_s2) + SW'(pyc_s2) + RND) >>> FRACTION_BITS;
		case (item_s2.mode)
			MODE_ADD: begin
				rx_nxt = RW'(item_s2.px) + RW'(pose_x);
				ry_nxt = RW'(item_s2.py) + RW'(pose_y);
			end
			MODE_SUB: begin
				rx_nxt = RW'(item_s2.px) - RW'(pose_x);
				ry_nxt = RW'(item_s2.py) - RW'(pose_y);
			end
			default: begin
				rx_nxt = sum_x[RW-1:0];
				ry_nxt = sum_y[RW-1:0];
			end
		endcase
	end

	// clamp when the bits above the sign of a 32-bit value disagree
	always_comb begin
		ovx = (rx_s3[RW-1:COORD_W-1] != {(RW-COORD_W+1){rx_s3[RW-1]}});
		ovy = (ry_s3[RW-1:COORD_W-1] != {(RW-COORD_W+1){ry_s3[RW-1]}});
		if (ovx) begin
			cx_nxt = rx_s3[RW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			cx_nxt = rx_s3[COORD_W-1:0];
		end
		if (ovy) begin
			cy_nxt = ry_s3[RW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			cy_nxt = ry_s3[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			cos_s1  <= item_in.flip ? -c_rnd : c_rnd;
			sin_s1  <= item_in.flip ? -s_rnd : s_rnd;
			item_s1 <= item_in;
		end
		if (ld[1]) begin
			pxc_s2  <= item_s1.px * cos_s1;
			pys_s2  <= item_s1.py * sin_s1;
			pxs_s2  <= item_s1.px * sin_s1;
			pyc_s2  <= item_s1.py * cos_s1;
			item_s2 <= item_s1;
		end
		if (ld[2]) begin
			rx_s3 <= rx_nxt;
			ry_s3 <= ry_nxt;
		end
		if (ld[3]) begin
			rx_s4  <= cx_nxt;
			ry_s4  <= cy_nxt;
			sat_s4 <= ovx | ovy;
		end
	end

	assign result_x  = rx_s4;
	assign result_y  = ry_s4;
	assign saturated = sat_s4;

endmodule

`default_nettype wire

/* hdl/planar_pose_transform.sv */
// planar_pose_transform: 2d pose step (rotate, offset add/subtract, inverse rotate) on a point
// stream; depends on ppt_pkg, ppt_angle_prep, ppt_cordic_cell, ppt_rotate_out
//
//   channel  dir  beat fields (low bit first)
//   s_*      in   tuser: mode[1:0]; tdata: point_x[31:0], point_y[63:32]
//   m_*      out  tuser: saturated; tdata: result_x[31:0], result_y[63:32]
//   cfg_*    in   cfg_addr 0 pose_x, 1 pose_y, 2 pose_heading (low 26 bits)
//
// one beat per cycle while the output is not stalled; the path runs through three heading stages,
// the cordic cell row (CORDIC_STAGES cells) and four multiply/saturate stages.
// every stage holds a valid bit and loads when it is empty or its successor loads,
// so a stall at the output is absorbed by empty stages before s_tready drops.
// reset clears the valid bits and the pose registers.
`timescale 1ns / 1ps
`default_nettype none

module planar_pose_transform #(
	parameter int unsigned CORDIC_STAGES = ppt_pkg::CORDIC_STAGES_DEF,
	parameter int unsigned FRACTION_BITS = ppt_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // point_x, point_y
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result_x, result_y
	output logic        m_tuser,   // saturated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);
	import ppt_pkg::*;

	localparam int unsigned NST = PREP_STAGES + CORDIC_STAGES + BACK_STAGES;

	logic signed [COORD_W-1:0]   pose_x_q, pose_y_q;
	logic signed [HEADING_W-1:0] pose_heading_q;

	logic [NST-1:0] vld_q, vin;
	logic [NST:0]   rdy;

	item_t                      item_in;
	logic signed [CORDIC_W-1:0] cx [0:CORDIC_STAGES];
	logic signed [CORDIC_W-1:0] cy [0:CORDIC_STAGES];
	logic signed [ANGLE_W-1:0]  cz [0:CORDIC_STAGES];
	item_t                      ci [0:CORDIC_STAGES];

	logic signed [COORD_W-1:0] res_x, res_y;
	logic                      res_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q       <= '0;
			pose_y_q       <= '0;
			pose_heading_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_POSE_X:       pose_x_q       <= cfg_wdata;
				CFG_POSE_Y:       pose_y_q       <= cfg_wdata;
				CFG_POSE_HEADING: pose_heading_q <= cfg_wdata[HEADING_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake chain
	assign rdy[NST] = m_tready;
	assign vin      = {vld_q[NST-2:0], s_tvalid};

	for (genvar k = 0; k < NST; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NST-1];

	always_comb begin
		item_in      = '0;
		item_in.mode = mode_t'(s_tuser);
		item_in.px   = s_tdata[31:0];
		item_in.py   = s_tdata[63:32];
	end

	ppt_angle_prep u_prep (
		.clk      (clk),
		.ld       (rdy[PREP_STAGES-1:0]),
		.heading  (pose_heading_q),
		.item_in  (item_in),
		.z_out    (cz[0]),
		.item_out (ci[0])
	);

	assign cx[0] = CORDIC_K;
	assign cy[0] = '0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ppt_cordic_cell #(
			.SHIFT (i)
		) u_cell (
			.clk      (clk),
			.ld       (rdy[PREP_STAGES+i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.item_in  (ci[i]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.item_out (ci[i+1])
		);
	end

	ppt_rotate_out #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_out (
		.clk       (clk),
		.ld        (rdy[NST-1:NST-BACK_STAGES]),
		.x_in      (cx[CORDIC_STAGES]),
		.y_in      (cy[CORDIC_STAGES]),
		.item_in   (ci[CORDIC_STAGES]),
		.pose_x    (pose_x_q),
		.pose_y    (pose_y_q),
		.result_x  (res_x),
		.result_y  (res_y),
		.saturated (res_sat)
	);

	assign m_tdata = {res_y, res_x};
	assign m_tuser = res_sat;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for planar_pose_transform: point stream against a bit-exact cordic pose predictor
// depends on ppt_pkg and the planar_pose_transform rtl; self-checking, no external files
`timescale 1ns / 1ps

module testbench;

	import ppt_pkg::*;

	localparam int ROT_STAGES = 18;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY = ROT_STAGES + 7;
	localparam int STALL_LIMIT = 5000;

	localparam longint HALF_REV = 180 * 65536;
	localparam longint QUARTER_REV = HALF_REV / 2;
	localparam longint FULL_REV = HALF_REV * 2;
	localparam longint GAIN_Q30 = 652032874;
	localparam int CORE_FRAC = 30;
	localparam longint CORE_HALF = longint'(1) << (CORE_FRAC - FRAC_BITS - 1);
	localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	localparam logic [31:0] PMAX = 32'h7fff_ffff;
	localparam logic [31:0] PMIN = 32'h8000_0000;

	typedef struct packed {
		logic        sat;
		logic [31:0] y;
		logic [31:0] x;
	} point_res_t;

	class pose_scoreboard;
		longint off_x, off_y, heading;
		longint atan_step[32];
		point_res_t expected_q[$];
		int errors, checked, clamped;

		function new();
			off_x = 0;
			off_y = 0;
			heading = 0;
			errors = 0;
			checked = 0;
			clamped = 0;
			atan_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115,
				57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			logic signed [25:0] h;
			h = v[25:0];
			case (cfg_idx_t'(idx))
				CFG_POSE_X: off_x = longint'($signed(v));
				CFG_POSE_Y: off_y = longint'($signed(v));
				CFG_POSE_HEADING: heading = longint'(h);
				default: ;
			endcase
		endfunction

		function void sin_cos(longint ang, output longint c, output longint s);
			longint m, x, y, z, nx;
			bit flip;
			flip = 0;
			m = ang % FULL_REV;
			if (m < 0)
				m += FULL_REV;
			if (m >= HALF_REV)
				m -= FULL_REV;
			if (m > QUARTER_REV) begin
				m -= HALF_REV;
				flip = 1;
			end else if (m < -QUARTER_REV) begin
				m += HALF_REV;
				flip = 1;
			end
			x = GAIN_Q30;
			y = 0;
			z = m;
			for (int i = 0; i < ROT_STAGES; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_step[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_step[i];
				end
				x = nx;
			end
			x = (x + CORE_HALF) >>> (CORE_FRAC - FRAC_BITS);
			y = (y + CORE_HALF) >>> (CORE_FRAC - FRAC_BITS);
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endfunction

		function longint clamp_coord(longint v, inout bit hit);
			if (v > COORD_MAX) begin
				hit = 1;
				return COORD_MAX;
			end
			if (v < COORD_MIN) begin
				hit = 1;
				return COORD_MIN;
			end
			return v;
		endfunction

		function void note_point(mode_t mode, logic [31:0] px_bits, logic [31:0] py_bits);
			longint px, py, rx, ry, c, s, h;
			bit hit;
			point_res_t want;
			px = longint'($signed(px_bits));
			py = longint'($signed(py_bits));
			hit = 0;
			case (mode)
				MODE_ADD: begin
					rx = px + off_x;
					ry = py + off_y;
				end
				MODE_SUB: begin
					rx = px - off_x;
					ry = py - off_y;
				end
				default: begin
					h = (mode == MODE_INV) ? -heading : heading;
					sin_cos(h, c, s);
					rx = (px * c - py * s + ROUND_HALF) >>> FRAC_BITS;
					ry = (px * s + py * c + ROUND_HALF) >>> FRAC_BITS;
				end
			endcase
			rx = clamp_coord(rx, hit);
			ry = clamp_coord(ry, hit);
			want.x = rx[31:0];
			want.y = ry[31:0];
			want.sat = hit;
			if (hit)
				clamped++;
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_result(logic [31:0] got_x, logic [31:0] got_y, logic got_sat);
			point_res_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat x=%h y=%h sat=%b", got_x, got_y, got_sat));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got_x !== want.x)
				report($sformatf("result_x %h, want %h", got_x, want.x));
			if (got_y !== want.y)
				report($sformatf("result_y %h, want %h", got_y, want.y));
			if (got_sat !== want.sat)
				report($sformatf("saturated %b, want %b", got_sat, want.sat));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_wdata;

	pose_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;
	int pose_count;

	int dir_headings[10] = '{0, 5898240, -5898240, 11796480, -11796480,
		23592960, -23592960, 2949120, 33554431, -33554432};
	int phase_send[4] = '{0, 80, 0, 12};
	int phase_stall[4] = '{0, 0, 80, 12};

	planar_pose_transform #(
		.CORDIC_STAGES(ROT_STAGES),
		.FRACTION_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_addr, cfg_wdata);
			if (s_tvalid && s_tready)
				sb.note_point(mode_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d results pending",
					quiet_cycles, sb.pending());
				$display("[planar_pose_transform] ERROR");
				$finish;
			end
		end
	end

	// called just after a falling edge, returns just after a falling edge
	task send_point(mode_t mode, logic [31:0] px, logic [31:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task set_pose(logic [31:0] x, logic [31:0] y, int h);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_POSE_X;
		cfg_wdata <= x;
		@(negedge clk);
		cfg_addr <= CFG_POSE_Y;
		cfg_wdata <= y;
		@(negedge clk);
		cfg_addr <= CFG_POSE_HEADING;
		cfg_wdata <= 32'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		pose_count++;
	endtask

	function logic [31:0] rand_coord();
		case ($urandom_range(6))
			0: return PMAX;
			1: return PMIN;
			2: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			3: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
			default: return $urandom;
		endcase
	endfunction

	function int rand_heading();
		logic signed [25:0] raw;
		raw = 26'($urandom);
		case ($urandom_range(3))
			0: return int'(raw);
			1: return (int'($urandom_range(0, 8)) - 4) * 5898240;
			default: return int'($urandom_range(0, 47185920)) - 23592960;
		endcase
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_ROT;
		cfg_we = 1'b0;
		cfg_addr = CFG_POSE_X;
		cfg_wdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		pose_count = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset pose
		send_point(MODE_ADD, PMAX, PMIN);
		send_point(MODE_ROT, 32'h0001_8000, 32'hfffe_8000);
		drain();

		// heading corners, wrap beyond a full turn, field extremes
		for (int k = 0; k < 10; k++) begin
			set_pose(PMAX, PMIN, dir_headings[k]);
			send_point(MODE_ROT, PMAX, PMIN);
			if (k % 2 == 0)
				send_point(MODE_INV, PMIN, PMAX);
			else
				send_point(MODE_INV, 32'h0001_0000, 32'hffff_0000);
			drain();
		end
		send_point(MODE_ADD, PMAX, PMIN);
		send_point(MODE_ADD, PMIN, PMAX);
		send_point(MODE_SUB, PMIN, PMAX);
		send_point(MODE_SUB, PMAX, PMIN);
		drain();

		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(3))
				0: set_pose(PMAX, PMIN, rand_heading());
				1: set_pose(PMIN, PMAX, rand_heading());
				default: set_pose(rand_coord(), rand_coord(), rand_heading());
			endcase
			send_idle_pct = phase_send[p % 4];
			stall_pct = phase_stall[p % 4];
			repeat (100)
				send_point(mode_t'($urandom_range(3)), rand_coord(), rand_coord());
			drain();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (2 * LATENCY) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("checked %0d points under %0d poses, %0d of them clamped",
			sb.checked, pose_count, sb.clamped);
		if (sb.errors == 0)
			$display("[planar_pose_transform] OK");
		else
			$display("[planar_pose_transform] ERROR");
		$finish;
	end

endmodule
